/* hdl/sact_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the set-associative cache tag lookup.
// No dependencies; imported by the top level and the checker.
package sact_pkg;

  localparam int ADDR_WIDTH = 32;
  localparam int VICTIM_W = 2;
  localparam int WAY_OUT_W = 2;
  localparam int COUNT_W = 32;
  localparam int ASSOC_W = 2;

  localparam int CACHE_BYTES_LOG2_DEF = 15;
  localparam int BLOCK_BYTES_LOG2_DEF = 6;
  localparam int MAX_WAYS_LOG2_DEF = 2;

  typedef struct packed {
    logic [ADDR_WIDTH-1:0] address;
    logic [VICTIM_W-1:0]   victim_way;
  } lookup_t;

  typedef struct packed {
    logic                 hit;
    logic [WAY_OUT_W-1:0] way_used;
    logic [COUNT_W-1:0]   hit_total;
    logic [COUNT_W-1:0]   miss_total;
  } result_t;

endpackage

/* hdl/sact_ram.sv */
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with registered read.
// Read during write to the same address returns the old contents. No dependencies.
module sact_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (re) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/set_assoc_cache_tag_lookup.sv */
`timescale 1ns / 1ps
// Tag lookup for a set-associative cache with 1, 2 or 4 ways and random replacement.
// Depends on sact_pkg and sact_ram.
//
// One lookup is accepted every cycle unless a clearing pass runs or the result stalls. The
// transfer edge reads one row of every way RAM and loads the compare stage; when that stage
// fires, it compares all ways of the set, updates the tag store and the counters and loads
// the output register. The per-way tag RAMs have a single write port, so after reset and
// after every write of the configuration register a clearing pass walks all rows (128 rows
// with the default geometry), during which no lookup is taken. A configuration write throws
// away every cached line but keeps the hit and miss totals.
module set_assoc_cache_tag_lookup
  import sact_pkg::*;
#(
  parameter int CACHE_BYTES_LOG2 = CACHE_BYTES_LOG2_DEF,
  parameter int BLOCK_BYTES_LOG2 = BLOCK_BYTES_LOG2_DEF,
  parameter int MAX_WAYS_LOG2    = MAX_WAYS_LOG2_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [ASSOC_W-1:0] cfg_data,
  input  logic               lookup_valid,
  output logic               lookup_ready,
  input  lookup_t            lookup,
  output logic               result_valid,
  input  logic               result_ready,
  output result_t            result
);

  localparam int LINES_LOG2 = CACHE_BYTES_LOG2 - BLOCK_BYTES_LOG2;
  localparam int WL = (MAX_WAYS_LOG2 < LINES_LOG2) ? MAX_WAYS_LOG2 : LINES_LOG2;
  localparam int LANES = 1 << WL;
  localparam int LANE_W = (WL > 0) ? WL : 1;
  localparam int ROW_W = (LINES_LOG2 - WL > 0) ? LINES_LOG2 - WL : 1;
  localparam int ROWS = 1 << ROW_W;
  localparam int TAG_W = ADDR_WIDTH - BLOCK_BYTES_LOG2 - LINES_LOG2 + WL;
  localparam int EXP_W = (WL > 0) ? $clog2(WL + 1) : 1;

  // configuration and clearing pass
  logic [ASSOC_W-1:0] assoc_exp;
  logic               clearing;
  logic [ROW_W-1:0]   clear_row;
  logic [EXP_W-1:0]   a_eff;

  // input decode
  logic [LINES_LOG2-1:0] line_idx;
  logic [LINES_LOG2-1:0] entry_idx;
  logic [ADDR_WIDTH-1:0] tag_shift;
  logic [ROW_W-1:0]      in_row;
  logic [LANE_W-1:0]     in_base_lane;
  logic [TAG_W-1:0]      in_tag;
  logic [LANE_W-1:0]     way_mask;

  // compare stage
  logic                s1_valid;
  logic [ROW_W-1:0]    s1_row;
  logic [LANE_W-1:0]   s1_base_lane;
  logic [TAG_W-1:0]    s1_tag;
  logic [VICTIM_W-1:0] s1_victim;
  logic                s1_fire;
  logic                load;

  // last tag write, missed by the row read issued at the same edge
  logic              fwd_valid;
  logic [ROW_W-1:0]  fwd_row;
  logic [LANE_W-1:0] fwd_lane;
  logic [TAG_W-1:0]  fwd_tag;

  logic [TAG_W:0]     lane_q     [LANES];
  logic               eff_valid  [LANES];
  logic [TAG_W-1:0]   eff_tag    [LANES];
  logic               in_set     [LANES];

  logic              hit_found;
  logic [LANE_W-1:0] hit_lane;
  logic              free_found;
  logic [LANE_W-1:0] free_lane;
  logic [LANE_W-1:0] fill_lane;
  logic [LANE_W-1:0] use_lane;
  logic              wr_en;

  logic [COUNT_W-1:0] hit_cnt;
  logic [COUNT_W-1:0] miss_cnt;
  logic [COUNT_W-1:0] hit_cnt_next;
  logic [COUNT_W-1:0] miss_cnt_next;

  assign cfg_ready = 1'b1;

  always_comb begin
    if (int'(assoc_exp) > WL) begin
      a_eff = EXP_W'(WL);
    end else begin
      a_eff = EXP_W'(assoc_exp);
    end
  end

  always_comb begin
    line_idx     = lookup.address[BLOCK_BYTES_LOG2 +: LINES_LOG2];
    entry_idx    = line_idx << a_eff;
    in_row       = ROW_W'(entry_idx >> WL);
    in_base_lane = LANE_W'(entry_idx) & LANE_W'(LANES - 1);
    tag_shift    = lookup.address >> (BLOCK_BYTES_LOG2 + LINES_LOG2 - int'(a_eff));
    in_tag       = TAG_W'(tag_shift);
    way_mask     = LANE_W'((1 << a_eff) - 1);
  end

  assign s1_fire      = s1_valid && (!result_valid || result_ready);
  assign lookup_ready = !clearing && (!s1_valid || s1_fire);
  assign load         = lookup_valid && lookup_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      assoc_exp <= '0;
      clearing  <= 1'b1;
      clear_row <= '0;
    end else if (cfg_valid && cfg_ready) begin
      assoc_exp <= cfg_data;
      clearing  <= 1'b1;
      clear_row <= '0;
    end else if (clearing) begin
      clear_row <= clear_row + ROW_W'(1);
      if (clear_row == ROW_W'(ROWS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      if (load) begin
        s1_valid  <= 1'b1;
        fwd_valid <= wr_en;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_row       <= in_row;
      s1_base_lane <= in_base_lane;
      s1_tag       <= in_tag;
      s1_victim    <= lookup.victim_way;
      fwd_row      <= s1_row;
      fwd_lane     <= fill_lane;
      fwd_tag      <= s1_tag;
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic           lane_we;
    logic [TAG_W:0] lane_wdata;
    logic           fwd_hit;

    assign lane_we    = clearing || (wr_en && fill_lane == LANE_W'(l));
    assign lane_wdata = clearing ? '0 : {1'b1, s1_tag};

    sact_ram #(
      .WIDTH (TAG_W + 1),
      .DEPTH (ROWS)
    ) u_ram (
      .clk     (clk),
      .we      (lane_we),
      .wr_addr (clearing ? clear_row : s1_row),
      .wr_data (lane_wdata),
      .re      (load),
      .rd_addr (in_row),
      .rd_data (lane_q[l])
    );

    assign fwd_hit      = fwd_valid && fwd_row == s1_row && fwd_lane == LANE_W'(l);
    assign eff_valid[l] = fwd_hit ? 1'b1 : lane_q[l][TAG_W];
    assign eff_tag[l]   = fwd_hit ? fwd_tag : lane_q[l][TAG_W-1:0];
    assign in_set[l]    = (LANE_W'(l) & ~way_mask) == s1_base_lane;
  end

  // lowest way wins in both searches
  always_comb begin
    hit_found  = 1'b0;
    hit_lane   = '0;
    free_found = 1'b0;
    free_lane  = '0;
    for (int l = LANES - 1; l >= 0; l--) begin
      if (in_set[l] && eff_valid[l] && eff_tag[l] == s1_tag) begin
        hit_found = 1'b1;
        hit_lane  = LANE_W'(l);
      end
      if (in_set[l] && !eff_valid[l]) begin
        free_found = 1'b1;
        free_lane  = LANE_W'(l);
      end
    end
  end

  always_comb begin
    if (free_found) begin
      fill_lane = free_lane;
    end else begin
      fill_lane = s1_base_lane | (LANE_W'(s1_victim) & way_mask);
    end
    use_lane      = hit_found ? hit_lane : fill_lane;
    wr_en         = s1_fire && !hit_found;
    hit_cnt_next  = hit_cnt + COUNT_W'(hit_found);
    miss_cnt_next = miss_cnt + COUNT_W'(!hit_found);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      hit_cnt      <= '0;
      miss_cnt     <= '0;
    end else begin
      if (s1_fire) begin
        result_valid <= 1'b1;
        hit_cnt      <= hit_cnt_next;
        miss_cnt     <= miss_cnt_next;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      result.hit        <= hit_found;
      result.way_used   <= WAY_OUT_W'(use_lane & way_mask);
      result.hit_total  <= hit_cnt_next;
      result.miss_total <= miss_cnt_next;
    end
  end

endmodule

/* hdl/sact_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the cache tag lookup, bound to the top level.
// Depends on sact_pkg and set_assoc_cache_tag_lookup.
module sact_checker
  import sact_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input logic [ASSOC_W-1:0] cfg_data,
  input logic               lookup_valid,
  input logic               lookup_ready,
  input lookup_t            lookup,
  input logic               result_valid,
  input logic               result_ready,
  input result_t            result
);

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // back to back transfers: totals advance by exactly one access
  a_hit_count: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_ready) ##1 (result_valid && result_ready)
    |-> result.hit_total == $past(result.hit_total) + COUNT_W'(result.hit))
    else $error("hit total out of step");

  a_miss_count: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_ready) ##1 (result_valid && result_ready)
    |-> result.miss_total == $past(result.miss_total) + COUNT_W'(!result.hit))
    else $error("miss total out of step");

  // clearing pass blocks lookups
  a_clear_blocks: assert property (@(posedge clk)
    (rst || (cfg_valid && cfg_ready)) |=> !lookup_ready)
    else $error("lookup taken during clearing pass");

endmodule

bind set_assoc_cache_tag_lookup sact_checker u_sact_checker (.*);
